### rtl/lhc_pkg.sv
// lhc_pkg: shared widths, class codes and helpers for the Luhn card classifier.
// No dependencies; compiled first.
package lhc_pkg;

  localparam int BIN_W          = 64;              // card number width
  localparam int DIG_W          = 4;               // one BCD digit
  localparam int NUM_DIGITS     = 20;              // decimal digits of a 64-bit value
  localparam int BCD_W          = NUM_DIGITS * DIG_W;
  localparam int BITS_PER_STAGE = 4;               // shift-add-3 steps per pipe stage
  localparam int NUM_STAGES     = BIN_W / BITS_PER_STAGE;
  localparam int NUM_GROUPS     = 4;               // digit groups summed in parallel
  localparam int GROUP_DIGITS   = NUM_DIGITS / NUM_GROUPS;
  localparam int GSUM_W         = 6;               // one group sum, at most 45
  localparam int SUM_W          = 8;               // full digit sum, at most 180
  localparam int CNT_W          = 5;
  localparam int LEAD_W         = 7;               // two leading digits, at most 99
  localparam int MAX_DIGITS_DEF = 19;

  // Reciprocal for sum / 10: (sum * 205) >> 11 is exact for sum below 1029.
  localparam int RECIP10       = 205;
  localparam int RECIP10_SHIFT = 11;
  localparam int RECIP10_W     = 8;

  localparam logic [LEAD_W-1:0] AMEX_LEAD_A = 7'd34;
  localparam logic [LEAD_W-1:0] AMEX_LEAD_B = 7'd37;
  localparam logic [LEAD_W-1:0] MC_LEAD_LO  = 7'd51;
  localparam logic [LEAD_W-1:0] MC_LEAD_HI  = 7'd55;
  localparam logic [LEAD_W-1:0] VISA_LEAD_LO = 7'd40;
  localparam logic [LEAD_W-1:0] VISA_LEAD_HI = 7'd49;
  localparam logic [CNT_W-1:0]  AMEX_LEN    = 5'd15;
  localparam logic [CNT_W-1:0]  MC_LEN      = 5'd16;
  localparam logic [CNT_W-1:0]  VISA_LEN_A  = 5'd13;
  localparam logic [CNT_W-1:0]  VISA_LEN_B  = 5'd16;

  typedef enum logic [1:0] {
    CLASS_INVALID    = 2'd0,
    CLASS_AMEX       = 2'd1,
    CLASS_MASTERCARD = 2'd2,
    CLASS_VISA       = 2'd3
  } card_class_t;

  // Binary-to-BCD conversion state carried down the pipe.
  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [BIN_W-1:0] bin;
  } dabble_t;

  // Luhn weight of one digit: doubled in even places, folded back below ten.
  function automatic logic [DIG_W-1:0] luhn_map(input logic [DIG_W-1:0] d,
                                                input logic dbl);
    logic [DIG_W:0] d2;
    d2 = {d, 1'b0};
    if (!dbl) begin
      luhn_map = d;
    end else if (d2 >= 5'd10) begin
      luhn_map = DIG_W'(d2 - 5'd9);
    end else begin
      luhn_map = d2[DIG_W-1:0];
    end
  endfunction

endpackage

### rtl/lhc_if.sv
// lhc_if: valid/ready channels for card items and classification results.
// Depends on lhc_pkg for field widths.
interface lhc_in_if;
  logic                       valid;
  logic                       ready;
  logic [lhc_pkg::BIN_W-1:0]  card_number;
  modport source (output valid, output card_number, input ready);
  modport sink   (input valid, input card_number, output ready);
endinterface

interface lhc_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 card_class;
  logic                       checksum_ok;
  logic [lhc_pkg::CNT_W-1:0]  digit_count;
  modport source (output valid, output card_class, output checksum_ok,
                  output digit_count, input ready);
  modport sink   (input valid, input card_class, input checksum_ok,
                  input digit_count, output ready);
endinterface

### rtl/lhc_dabble_stage.sv
// lhc_dabble_stage: one registered slice of the binary-to-BCD converter.
// Depends on lhc_pkg (dabble_t, widths).
module lhc_dabble_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  input  lhc_pkg::dabble_t up_data,
  input  logic             dn_load,
  output logic             load,
  output logic             valid_r,
  output lhc_pkg::dabble_t data_r
);

  lhc_pkg::dabble_t data_nxt;

  // Take a new item when empty or when the downstream stage takes ours.
  assign load = !valid_r || dn_load;

  // Shift-add-3: adjust every digit of 5 or more, then shift in the next bit.
  always_comb begin
    data_nxt = up_data;
    for (int s = 0; s < lhc_pkg::BITS_PER_STAGE; s++) begin
      for (int k = 0; k < lhc_pkg::NUM_DIGITS; k++) begin
        if (data_nxt.bcd[k*lhc_pkg::DIG_W +: lhc_pkg::DIG_W] >= 4'd5) begin
          data_nxt.bcd[k*lhc_pkg::DIG_W +: lhc_pkg::DIG_W] =
            data_nxt.bcd[k*lhc_pkg::DIG_W +: lhc_pkg::DIG_W] + 4'd3;
        end
      end
      data_nxt.bcd = {data_nxt.bcd[lhc_pkg::BCD_W-2:0], data_nxt.bin[lhc_pkg::BIN_W-1]};
      data_nxt.bin = {data_nxt.bin[lhc_pkg::BIN_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

endmodule

### rtl/luhn_card_classifier.sv
// Luhn card classifier: registered pipe of 16 binary-to-BCD stages of 4 bits each,
// then stages P1 (digit count, group sums), P2 (total sum, leading digits), P3 (class).
// Throughput: one item per cycle unless stalled; each stage holds its item only
// while the stage after it is full and stalled, so bubbles close up under backpressure.
// Reset (rst_n low, synchronous) empties every stage; payload registers keep junk.
// Depends on lhc_pkg, lhc_if and lhc_dabble_stage.
module luhn_card_classifier #(
  parameter int MAX_DIGITS = lhc_pkg::MAX_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lhc_in_if.sink     in_chan,
  lhc_out_if.source  out_chan
);

  localparam int NS = lhc_pkg::NUM_STAGES;

  // ---------------------------------------------------------------------------
  // Binary-to-BCD pipe: each stage does four shift-add-3 steps.
  // ---------------------------------------------------------------------------
  logic             dab_v    [NS];
  logic             dab_load [NS];
  lhc_pkg::dabble_t dab_q    [NS];
  lhc_pkg::dabble_t dab_in0;
  logic             p1_load;

  assign dab_in0.bcd = '0;
  assign dab_in0.bin = in_chan.card_number;
  assign in_chan.ready = dab_load[0];

  for (genvar i = 0; i < NS; i++) begin : g_dab
    logic             up_v;
    lhc_pkg::dabble_t up_d;
    logic             dn_ld;
    if (i == 0) begin : g_first
      assign up_v = in_chan.valid;
      assign up_d = dab_in0;
    end else begin : g_mid
      assign up_v = dab_v[i-1];
      assign up_d = dab_q[i-1];
    end
    if (i == NS - 1) begin : g_last
      assign dn_ld = p1_load;
    end else begin : g_next
      assign dn_ld = dab_load[i+1];
    end
    lhc_dabble_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (up_v),
      .up_data  (up_d),
      .dn_load  (dn_ld),
      .load     (dab_load[i]),
      .valid_r  (dab_v[i]),
      .data_r   (dab_q[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage P1: digit count and Luhn group sums.
  // ---------------------------------------------------------------------------
  logic                      p1_v_r;
  logic [lhc_pkg::BCD_W-1:0] p1_bcd_r;
  logic [lhc_pkg::CNT_W-1:0] p1_cnt_r, p1_cnt_nxt;
  logic [lhc_pkg::GSUM_W-1:0] p1_gsum_r [lhc_pkg::NUM_GROUPS];
  logic [lhc_pkg::GSUM_W-1:0] p1_gsum_nxt [lhc_pkg::NUM_GROUPS];
  logic                      p2_load;

  assign p1_load = !p1_v_r || p2_load;

  always_comb begin
    logic [lhc_pkg::BCD_W-1:0] bcd;
    logic [lhc_pkg::DIG_W-1:0] d;
    int                        g;
    bcd = dab_q[NS-1].bcd;
    // Zero still counts as one digit.
    p1_cnt_nxt = 5'd1;
    for (int k = 0; k < lhc_pkg::NUM_DIGITS; k++) begin
      if (bcd[k*lhc_pkg::DIG_W +: lhc_pkg::DIG_W] != '0) begin
        p1_cnt_nxt = lhc_pkg::CNT_W'(k + 1);
      end
    end
    for (int j = 0; j < lhc_pkg::NUM_GROUPS; j++) begin
      p1_gsum_nxt[j] = '0;
    end
    // Digits past the top are zero and add nothing.
    for (int k = 0; k < lhc_pkg::NUM_DIGITS; k++) begin
      g = k / lhc_pkg::GROUP_DIGITS;
      d = lhc_pkg::luhn_map(bcd[k*lhc_pkg::DIG_W +: lhc_pkg::DIG_W], (k % 2) == 1);
      p1_gsum_nxt[g] = p1_gsum_nxt[g] + lhc_pkg::GSUM_W'(d);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (p1_load) begin
      p1_v_r <= dab_v[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (p1_load) begin
      p1_bcd_r  <= dab_q[NS-1].bcd;
      p1_cnt_r  <= p1_cnt_nxt;
      p1_gsum_r <= p1_gsum_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage P2: total sum, leading two digits, digit-limit check.
  // ---------------------------------------------------------------------------
  logic                       p2_v_r;
  logic [lhc_pkg::SUM_W-1:0]  p2_sum_r, p2_sum_nxt;
  logic [lhc_pkg::LEAD_W-1:0] p2_lead_r, p2_lead_nxt;
  logic [lhc_pkg::CNT_W-1:0]  p2_cnt_r;
  logic                       p2_over_r, p2_over_nxt;
  logic                       p3_load;

  assign p2_load = !p2_v_r || p3_load;

  always_comb begin
    logic [lhc_pkg::DIG_W-1:0] digs [lhc_pkg::NUM_DIGITS];
    logic [lhc_pkg::DIG_W-1:0] tens;
    logic [lhc_pkg::DIG_W-1:0] units;
    for (int k = 0; k < lhc_pkg::NUM_DIGITS; k++) begin
      digs[k] = p1_bcd_r[k*lhc_pkg::DIG_W +: lhc_pkg::DIG_W];
    end
    p2_sum_nxt = '0;
    for (int j = 0; j < lhc_pkg::NUM_GROUPS; j++) begin
      p2_sum_nxt = p2_sum_nxt + lhc_pkg::SUM_W'(p1_gsum_r[j]);
    end
    // A single digit is the tens with units zero; only lengths of 13 and up are classified.
    tens  = digs[p1_cnt_r - 5'd1];
    units = (p1_cnt_r >= 5'd2) ? digs[p1_cnt_r - 5'd2] : '0;
    p2_lead_nxt = lhc_pkg::LEAD_W'(tens) * 7'd10 + lhc_pkg::LEAD_W'(units);
    p2_over_nxt = p1_cnt_r > lhc_pkg::CNT_W'(MAX_DIGITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (p2_load) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_load) begin
      p2_sum_r  <= p2_sum_nxt;
      p2_lead_r <= p2_lead_nxt;
      p2_cnt_r  <= p1_cnt_r;
      p2_over_r <= p2_over_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage P3 (output register): mod-10 test and classification.
  // ---------------------------------------------------------------------------
  logic                      p3_v_r;
  lhc_pkg::card_class_t      p3_class_r, p3_class_nxt;
  logic                      p3_ok_r, p3_ok_nxt;
  logic [lhc_pkg::CNT_W-1:0] p3_cnt_r, p3_cnt_nxt;

  assign p3_load = !p3_v_r || out_chan.ready;

  always_comb begin
    logic [lhc_pkg::SUM_W+lhc_pkg::RECIP10_W-1:0] prod;
    logic [lhc_pkg::SUM_W-1:0]                    quo;
    logic [lhc_pkg::SUM_W-1:0]                    tenx;
    logic                                         sum_ok;
    prod   = p2_sum_r * lhc_pkg::RECIP10_W'(lhc_pkg::RECIP10);
    quo    = lhc_pkg::SUM_W'(prod >> lhc_pkg::RECIP10_SHIFT);
    tenx   = lhc_pkg::SUM_W'(quo * 4'd10);
    sum_ok = (tenx == p2_sum_r);

    p3_class_nxt = lhc_pkg::CLASS_INVALID;
    if (p2_over_r) begin
      // Too many digits: clamp the count, fail the checksum.
      p3_ok_nxt  = 1'b0;
      p3_cnt_nxt = lhc_pkg::CNT_W'(MAX_DIGITS + 1);
    end else begin
      p3_ok_nxt  = sum_ok;
      p3_cnt_nxt = p2_cnt_r;
      if (sum_ok) begin
        if (p2_cnt_r == lhc_pkg::AMEX_LEN &&
            (p2_lead_r == lhc_pkg::AMEX_LEAD_A || p2_lead_r == lhc_pkg::AMEX_LEAD_B)) begin
          p3_class_nxt = lhc_pkg::CLASS_AMEX;
        end else if (p2_cnt_r == lhc_pkg::MC_LEN &&
                     p2_lead_r inside {[lhc_pkg::MC_LEAD_LO:lhc_pkg::MC_LEAD_HI]}) begin
          p3_class_nxt = lhc_pkg::CLASS_MASTERCARD;
        end else if ((p2_cnt_r == lhc_pkg::VISA_LEN_A || p2_cnt_r == lhc_pkg::VISA_LEN_B) &&
                     p2_lead_r inside {[lhc_pkg::VISA_LEAD_LO:lhc_pkg::VISA_LEAD_HI]}) begin
          p3_class_nxt = lhc_pkg::CLASS_VISA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else if (p3_load) begin
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p3_load) begin
      p3_class_r <= p3_class_nxt;
      p3_ok_r    <= p3_ok_nxt;
      p3_cnt_r   <= p3_cnt_nxt;
    end
  end

  assign out_chan.valid       = p3_v_r;
  assign out_chan.card_class  = p3_class_r;
  assign out_chan.checksum_ok = p3_ok_r;
  assign out_chan.digit_count = p3_cnt_r;

endmodule

### rtl/lhc_checker.sv
// lhc_checker: port-level assertions for the Luhn card classifier, bound to the top.
// Depends on lhc_pkg and luhn_card_classifier.
module lhc_checker #(
  parameter int MAX_DIGITS = lhc_pkg::MAX_DIGITS_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                card_class,
  input logic                      checksum_ok,
  input logic [lhc_pkg::CNT_W-1:0] digit_count
);

  // Reset empties the pipe.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(card_class) && $stable(checksum_ok) && $stable(digit_count))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> digit_count >= 5'd1 && digit_count <= lhc_pkg::CNT_W'(MAX_DIGITS + 1))
    else $error("digit count out of range");

  // Any real class needs a passing checksum and a count within the limit.
  a_class_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && card_class != lhc_pkg::CLASS_INVALID |->
      checksum_ok && digit_count <= lhc_pkg::CNT_W'(MAX_DIGITS))
    else $error("class given without valid checksum");

  a_class_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (card_class != lhc_pkg::CLASS_AMEX || digit_count == lhc_pkg::AMEX_LEN) &&
      (card_class != lhc_pkg::CLASS_MASTERCARD || digit_count == lhc_pkg::MC_LEN) &&
      (card_class != lhc_pkg::CLASS_VISA || digit_count == lhc_pkg::VISA_LEN_A ||
       digit_count == lhc_pkg::VISA_LEN_B))
    else $error("class does not match digit count");

endmodule

bind luhn_card_classifier lhc_checker #(.MAX_DIGITS(MAX_DIGITS)) u_lhc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .card_class  (out_chan.card_class),
  .checksum_ok (out_chan.checksum_ok),
  .digit_count (out_chan.digit_count)
);
